// ===== hdl/chc_pkg.sv =====
`timescale 1ns / 1ps

package chc_pkg;

  localparam int DATA_W               = 16;
  localparam int OP_W                 = 2;
  localparam int HEAD_W               = 15;
  localparam int HEADING_FRAC_BITS_DEF = 6;

  localparam int IN_SHIFT     = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int ACC_FRAC     = 16;
  localparam int XY_W         = 34;
  localparam int ACC_W        = 27;
  localparam int ATAN_W       = 22;

  localparam logic signed [ACC_W-1:0] DEG180_ACC = ACC_W'(180 * 65536);
  localparam logic signed [ACC_W-1:0] DEG360_ACC = ACC_W'(360 * 65536);

  localparam logic signed [DATA_W-1:0] TRACK_MIN_ARM = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] TRACK_MAX_ARM = 16'sh8000;

  localparam logic [OP_W-1:0] OP_MEASURE = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL     = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } hdg_stat_t;

  // Arctangent of 2^-i in degrees, scaled by 2^16 and rounded.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] t;
    unique case (idx)
      4'd0:  t = 22'd2949120;
      4'd1:  t = 22'd1740967;
      4'd2:  t = 22'd919879;
      4'd3:  t = 22'd466945;
      4'd4:  t = 22'd234379;
      4'd5:  t = 22'd117304;
      4'd6:  t = 22'd58666;
      4'd7:  t = 22'd29335;
      4'd8:  t = 22'd14668;
      4'd9:  t = 22'd7334;
      4'd10: t = 22'd3667;
      4'd11: t = 22'd1833;
      4'd12: t = 22'd917;
      4'd13: t = 22'd458;
      4'd14: t = 22'd229;
      4'd15: t = 22'd115;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Midpoint of two signed words, truncated toward zero.
  function automatic logic signed [DATA_W-1:0] midpoint(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W]) begin
      s = s + (DATA_W+1)'(1);
    end
    s = s >>> 1;
    return s[DATA_W-1:0];
  endfunction

endpackage

// ===== hdl/chc_if.sv =====
`timescale 1ns / 1ps

interface chc_in_if;
  logic                                valid;
  logic                                ready;
  logic [chc_pkg::OP_W-1:0]            op;
  logic signed [chc_pkg::DATA_W-1:0]   raw_x;
  logic signed [chc_pkg::DATA_W-1:0]   raw_y;
  logic signed [chc_pkg::DATA_W-1:0]   raw_z;

  modport source (output valid, op, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, op, raw_x, raw_y, raw_z, output ready);
endinterface

interface chc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [chc_pkg::DATA_W-1:0]   corrected_x;
  logic signed [chc_pkg::DATA_W-1:0]   corrected_y;
  logic signed [chc_pkg::DATA_W-1:0]   z_out;
  logic [chc_pkg::HEAD_W-1:0]          heading;
  logic signed [chc_pkg::DATA_W-1:0]   offset_x_now;
  logic signed [chc_pkg::DATA_W-1:0]   offset_y_now;

  modport source (output valid, corrected_x, corrected_y, z_out, heading, offset_x_now,
                  offset_y_now, input ready);
  modport sink   (input valid, corrected_x, corrected_y, z_out, heading, offset_x_now,
                  offset_y_now, output ready);
endinterface

// ===== hdl/chc_cordic_step.sv =====
`timescale 1ns / 1ps

module chc_cordic_step (
  input  logic signed [chc_pkg::XY_W-1:0]   x_i,
  input  logic signed [chc_pkg::XY_W-1:0]   y_i,
  input  logic signed [chc_pkg::ACC_W-1:0]  acc_i,
  input  logic [chc_pkg::STEP_W-1:0]        idx_i,
  output logic signed [chc_pkg::XY_W-1:0]   x_o,
  output logic signed [chc_pkg::XY_W-1:0]   y_o,
  output logic signed [chc_pkg::ACC_W-1:0]  acc_o
);
  import chc_pkg::*;

  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [ACC_W-1:0] t;

  always_comb begin
    xs = x_i >>> idx_i;
    ys = y_i >>> idx_i;
    t  = signed'({{(ACC_W-ATAN_W){1'b0}}, atan_q16(idx_i)});
    if (!y_i[XY_W-1]) begin
      x_o   = x_i + ys;
      y_o   = y_i - xs;
      acc_o = acc_i + t;
    end else begin
      x_o   = x_i - ys;
      y_o   = y_i + xs;
      acc_o = acc_i - t;
    end
  end

endmodule

// ===== hdl/chc_heading.sv =====
`timescale 1ns / 1ps

module chc_heading #(
  parameter int HEADING_FRAC_BITS = chc_pkg::HEADING_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic signed [chc_pkg::DATA_W-1:0]  cx_i,
  input  logic signed [chc_pkg::DATA_W-1:0]  cy_i,
  output chc_pkg::hdg_stat_t                 stat_o,
  output logic [chc_pkg::HEAD_W-1:0]         heading_o
);
  import chc_pkg::*;

  localparam int RND_SH = ACC_FRAC - HEADING_FRAC_BITS;
  localparam int HALF_I = 1 << (RND_SH - 1);
  localparam int FULL_I = 360 << HEADING_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(HALF_I);
  localparam logic [ACC_W-1:0] FULL = ACC_W'(FULL_I);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                     run_r;
  logic                     rnd_r;
  logic                     done_r;
  logic [STEP_W-1:0]        cnt_r;
  logic signed [XY_W-1:0]   x_r;
  logic signed [XY_W-1:0]   y_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     zero_r;
  logic [HEAD_W-1:0]        heading_r;

  logic signed [XY_W-1:0]   x_step;
  logic signed [XY_W-1:0]   y_step;
  logic signed [ACC_W-1:0]  acc_step;
  logic signed [XY_W-1:0]   x_ld;
  logic signed [XY_W-1:0]   y_ld;
  logic [ACC_W-1:0]         acc_pos;
  logic [ACC_W-1:0]         rnd_q;
  logic [ACC_W-1:0]         rnd_w;
  logic [HEAD_W-1:0]        heading_nxt;

  chc_cordic_step u_step (
    .x_i   (x_r),
    .y_i   (y_r),
    .acc_i (acc_r),
    .idx_i (cnt_r),
    .x_o   (x_step),
    .y_o   (y_step),
    .acc_o (acc_step)
  );

  assign x_ld = {{(XY_W-DATA_W-IN_SHIFT){cx_i[DATA_W-1]}}, cx_i, {IN_SHIFT{1'b0}}};
  assign y_ld = {{(XY_W-DATA_W-IN_SHIFT){cy_i[DATA_W-1]}}, cy_i, {IN_SHIFT{1'b0}}};

  always_comb begin
    acc_pos = acc_r[ACC_W-1] ? unsigned'(acc_r + DEG360_ACC) : unsigned'(acc_r);
    rnd_q   = (acc_pos + HALF) >> RND_SH;
    rnd_w   = (rnd_q >= FULL) ? (rnd_q - FULL) : rnd_q;
    heading_nxt = zero_r ? '0 : rnd_w[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == LAST_STEP) begin
          run_r <= 1'b0;
          rnd_r <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      zero_r <= (cx_i == '0) && (cy_i == '0);
      if (cx_i[DATA_W-1]) begin
        x_r   <= -x_ld;
        y_r   <= -y_ld;
        acc_r <= DEG180_ACC;
      end else begin
        x_r   <= x_ld;
        y_r   <= y_ld;
        acc_r <= '0;
      end
    end else if (run_r) begin
      x_r   <= x_step;
      y_r   <= y_step;
      acc_r <= acc_step;
    end
    if (rnd_r) begin
      heading_r <= heading_nxt;
    end
  end

  assign stat_o.busy = run_r || rnd_r;
  assign stat_o.done = done_r;
  assign heading_o   = heading_r;

endmodule

// ===== hdl/compass_heading_with_offset_calibration.sv =====
`timescale 1ns / 1ps

// Compass heading with hard-iron offset calibration.
// The input channel carries an op code and raw X, Y and Z magnetometer words.
// A measure transaction subtracts the stored X and Y offsets and returns the
// heading in 1/64 degree steps; a calibration transaction widens the raw X and
// Y min/max trackers; a finish transaction loads each offset with the midpoint
// of its trackers and re-arms them. Every input transaction yields exactly one
// result transaction carrying the corrected pair, Z, the heading and the
// offsets in force afterwards.
// From input acceptance to result valid the block updates the offsets and
// trackers, runs sixteen iterations of the shared CORDIC step unit, rounds
// the angle and writes the output register. One item is processed at a time.
// The result sits in an output register, so a new input is taken while a
// finished result still waits; a stalled receiver holds the block only once
// the next result is ready to be written.
// Synchronous reset clears the offsets to zero, arms the trackers and empties
// the output register.
module compass_heading_with_offset_calibration #(
  parameter int HEADING_FRAC_BITS = chc_pkg::HEADING_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  chc_in_if.sink    in_chan,
  chc_out_if.source out_chan
);
  import chc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [OP_W-1:0]          op_r;
  logic signed [DATA_W-1:0] rx_r;
  logic signed [DATA_W-1:0] ry_r;
  logic signed [DATA_W-1:0] rz_r;
  logic signed [DATA_W-1:0] cx_r;
  logic signed [DATA_W-1:0] cy_r;

  logic signed [DATA_W-1:0] off_x_r;
  logic signed [DATA_W-1:0] off_y_r;
  logic signed [DATA_W-1:0] min_x_r;
  logic signed [DATA_W-1:0] max_x_r;
  logic signed [DATA_W-1:0] min_y_r;
  logic signed [DATA_W-1:0] max_y_r;
  logic signed [DATA_W-1:0] off_x_nxt;
  logic signed [DATA_W-1:0] off_y_nxt;
  logic signed [DATA_W-1:0] min_x_nxt;
  logic signed [DATA_W-1:0] max_x_nxt;
  logic signed [DATA_W-1:0] min_y_nxt;
  logic signed [DATA_W-1:0] max_y_nxt;
  logic signed [DATA_W-1:0] cx_nxt;
  logic signed [DATA_W-1:0] cy_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_cx_r;
  logic signed [DATA_W-1:0] out_cy_r;
  logic signed [DATA_W-1:0] out_z_r;
  logic [HEAD_W-1:0]        out_head_r;
  logic signed [DATA_W-1:0] out_offx_r;
  logic signed [DATA_W-1:0] out_offy_r;

  logic                     in_fire;
  logic                     prep;
  logic                     load_out;
  hdg_stat_t                hdg_stat;
  logic [HEAD_W-1:0]        hdg_heading;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign prep     = (state_r == ST_PREP);
  assign load_out = (state_r == ST_DRAIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    unique case (op_r)
      OP_CAL: begin
        if (rx_r < min_x_r) min_x_nxt = rx_r;
        if (rx_r > max_x_r) max_x_nxt = rx_r;
        if (ry_r < min_y_r) min_y_nxt = ry_r;
        if (ry_r > max_y_r) max_y_nxt = ry_r;
      end
      OP_FINISH: begin
        off_x_nxt = midpoint(max_x_r, min_x_r);
        off_y_nxt = midpoint(max_y_r, min_y_r);
        min_x_nxt = TRACK_MIN_ARM;
        max_x_nxt = TRACK_MAX_ARM;
        min_y_nxt = TRACK_MIN_ARM;
        max_y_nxt = TRACK_MAX_ARM;
      end
      default: begin
      end
    endcase
    cx_nxt = rx_r - off_x_nxt;
    cy_nxt = ry_r - off_y_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_RUN;
      ST_RUN:   if (hdg_stat.done) state_nxt = ST_DRAIN;
      ST_DRAIN: if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  chc_heading #(
    .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
  ) u_heading (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (prep),
    .cx_i      (cx_nxt),
    .cy_i      (cy_nxt),
    .stat_o    (hdg_stat),
    .heading_o (hdg_heading)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      min_x_r     <= TRACK_MIN_ARM;
      max_x_r     <= TRACK_MAX_ARM;
      min_y_r     <= TRACK_MIN_ARM;
      max_y_r     <= TRACK_MAX_ARM;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (prep) begin
        off_x_r <= off_x_nxt;
        off_y_r <= off_y_nxt;
        min_x_r <= min_x_nxt;
        max_x_r <= max_x_nxt;
        min_y_r <= min_y_nxt;
        max_y_r <= max_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_chan.op;
      rx_r <= in_chan.raw_x;
      ry_r <= in_chan.raw_y;
      rz_r <= in_chan.raw_z;
    end
    if (prep) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
    if (load_out) begin
      out_cx_r   <= cx_r;
      out_cy_r   <= cy_r;
      out_z_r    <= rz_r;
      out_head_r <= hdg_heading;
      out_offx_r <= off_x_r;
      out_offy_r <= off_y_r;
    end
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.corrected_x  = out_cx_r;
  assign out_chan.corrected_y  = out_cy_r;
  assign out_chan.z_out        = out_z_r;
  assign out_chan.heading      = out_head_r;
  assign out_chan.offset_x_now = out_offx_r;
  assign out_chan.offset_y_now = out_offy_r;

endmodule

// ===== hdl/chc_checker.sv =====
`timescale 1ns / 1ps

module chc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [chc_pkg::DATA_W-1:0] corrected_x,
  input logic signed [chc_pkg::DATA_W-1:0] corrected_y,
  input logic [chc_pkg::HEAD_W-1:0]        heading
);
  import chc_pkg::*;

  // The result register is empty straight after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Once a transaction is taken the block stays busy for the following cycles.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted while an item is in progress");

  // A zero corrected vector has heading zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (corrected_x == '0) && (corrected_y == '0) |-> (heading == '0))
    else $error("zero vector gave a non-zero heading");

  // A stalled result holds its heading.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(heading))
    else $error("stalled result changed");

endmodule

bind compass_heading_with_offset_calibration chc_checker u_chc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .corrected_x (out_chan.corrected_x),
  .corrected_y (out_chan.corrected_y),
  .heading     (out_chan.heading)
);
